FILE: design/masked_segment_spike_rate_assert.svh
// assertion macros for the masked segment spike rate block
// no dependencies; taken in by the rtl files that check their own logic
`ifndef MASKED_SEGMENT_SPIKE_RATE_ASSERT_SVH
`define MASKED_SEGMENT_SPIKE_RATE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/msr_pkg.sv
// shared widths and constants of the masked segment spike rate block
// no dependencies
`default_nettype none

package msr_pkg;

   localparam int unsigned ValueWidth = 8;
   localparam int unsigned SumWidth   = 24;
   localparam int unsigned CountWidth = 17;
   localparam int unsigned RateWidth  = 8;

   // dividend 510*sum + count, divisor 2*count
   localparam int unsigned NumWidth   = 34;
   localparam int unsigned DenWidth   = CountWidth + 1;
   // remainder width once the quotient is known to fit in RateWidth bits
   localparam int unsigned RemWidth   = DenWidth + RateWidth;
   localparam int unsigned StepWidth  = 3;

   localparam logic [SumWidth-1:0]   SumMax   = '1;
   localparam logic [CountWidth-1:0] CountMax = '1;
   localparam logic [RateWidth-1:0]  RateMax  = 8'd255;
   localparam logic [RateWidth-1:0]  RateZero = 8'h00;

endpackage

`default_nettype wire

FILE: design/masked_segment_spike_rate.sv
// masked segment spike rate: masked sum and rounded rate per group
// depends on msr_pkg and masked_segment_spike_rate_assert.svh
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | spike_value, excluded, group_last
//   rsp     | out | rsp_valid/rsp_ready  | spike_sum, rate_byte, empty_group
//
// items without the group end marker are taken back to back, one per cycle.
// a group end beat is followed by a multiply state, a saturation check state,
// shift-subtract divide steps, one per quotient bit, and a load state for the
// result register, after which req_ready rises again; an empty or saturated
// group skips the divide.
// reset clears the accumulators, the sequencer and rsp_valid.
// the result register lets new beats of the next group enter while rsp stalls;
// a further group end waits in the load state until the held result is taken.
`default_nettype none

module masked_segment_spike_rate (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [msr_pkg::ValueWidth-1:0] req_spike_value,
   input  wire logic                           req_excluded,
   input  wire logic                           req_group_last,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [msr_pkg::SumWidth-1:0]        rsp_spike_sum,
   output logic [msr_pkg::RateWidth-1:0]       rsp_rate_byte,
   output logic                                rsp_empty_group
);

   localparam logic [2:0] ST_ACC  = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_CHK  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]                        state_ff, state_in;
   logic [msr_pkg::SumWidth-1:0]      sum_acc_ff, sum_acc_in;
   logic [msr_pkg::CountWidth-1:0]    cnt_acc_ff, cnt_acc_in;
   logic [msr_pkg::SumWidth-1:0]      sum_w_ff, sum_w_in;
   logic [msr_pkg::CountWidth-1:0]    cnt_w_ff, cnt_w_in;
   logic [msr_pkg::NumWidth-1:0]      num_ff, num_in;
   logic [msr_pkg::DenWidth-1:0]      den_ff, den_in;
   logic [msr_pkg::RemWidth-1:0]      rem_ff, rem_in;
   logic [msr_pkg::RemWidth-1:0]      dsh_ff, dsh_in;
   logic [msr_pkg::RateWidth-1:0]     q_ff, q_in;
   logic [msr_pkg::StepWidth-1:0]     step_ff, step_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [msr_pkg::SumWidth-1:0]      rsp_sum_ff, rsp_sum_in;
   logic [msr_pkg::RateWidth-1:0]     rsp_rate_ff, rsp_rate_in;
   logic                              rsp_empty_ff, rsp_empty_in;

   logic                              req_beat;
   logic [msr_pkg::SumWidth:0]        sum_add;
   logic [msr_pkg::SumWidth-1:0]      sum_next;
   logic [msr_pkg::CountWidth-1:0]    cnt_next;
   logic [msr_pkg::NumWidth-1:0]      sat_limit;
   logic                              div_fits;
   logic [msr_pkg::RemWidth-1:0]      rem_diff;
   logic                              out_free;

   assign req_ready = (state_ff == ST_ACC);
   assign req_beat  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // saturating masked accumulate of the current beat
   assign sum_add  = {1'b0, sum_acc_ff} + (msr_pkg::SumWidth+1)'(req_spike_value);
   assign sum_next = req_excluded ? sum_acc_ff
                   : (sum_add[msr_pkg::SumWidth] ? msr_pkg::SumMax
                                                 : sum_add[msr_pkg::SumWidth-1:0]);
   assign cnt_next = (req_excluded || cnt_acc_ff == msr_pkg::CountMax) ? cnt_acc_ff
                   : cnt_acc_ff + 1'b1;

   // quotient above 255 exactly when the dividend reaches 256 divisors
   assign sat_limit = msr_pkg::NumWidth'({den_ff, msr_pkg::RateWidth'(0)});

   // shared compare-subtract unit of the divider
   assign div_fits = (rem_ff >= dsh_ff);
   assign rem_diff = rem_ff - dsh_ff;

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      sum_acc_in   = sum_acc_ff;
      cnt_acc_in   = cnt_acc_ff;
      sum_w_in     = sum_w_ff;
      cnt_w_in     = cnt_w_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      q_in         = q_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_empty_in = rsp_empty_ff;
      case (state_ff)
         ST_ACC: begin
            if (req_beat) begin
               if (req_group_last) begin
                  sum_w_in   = sum_next;
                  cnt_w_in   = cnt_next;
                  sum_acc_in = '0;
                  cnt_acc_in = '0;
                  state_in   = ST_MUL;
               end else begin
                  sum_acc_in = sum_next;
                  cnt_acc_in = cnt_next;
               end
            end
         end
         ST_MUL: begin
            // 510*sum as (sum << 9) - (sum << 1), plus count for half-up rounding
            num_in   = (msr_pkg::NumWidth'(sum_w_ff) << 9)
                     - (msr_pkg::NumWidth'(sum_w_ff) << 1)
                     + msr_pkg::NumWidth'(cnt_w_ff);
            den_in   = {cnt_w_ff, 1'b0};
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (cnt_w_ff == '0) begin
               q_in     = msr_pkg::RateZero;
               state_in = ST_DONE;
            end else if (num_ff >= sat_limit) begin
               q_in     = msr_pkg::RateMax;
               state_in = ST_DONE;
            end else begin
               rem_in   = num_ff[msr_pkg::RemWidth-1:0];
               dsh_in   = {1'b0, den_ff, (msr_pkg::RateWidth-1)'(0)};
               q_in     = '0;
               step_in  = '1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle, msb first
            if (div_fits) begin
               rem_in = rem_diff;
            end
            q_in    = {q_ff[msr_pkg::RateWidth-2:0], div_fits};
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = sum_w_ff;
               rsp_rate_in  = q_ff;
               rsp_empty_in = (cnt_w_ff == '0);
               state_in     = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         sum_acc_ff   <= '0;
         cnt_acc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_acc_ff   <= sum_acc_in;
         cnt_acc_ff   <= cnt_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and divider working registers
   always_ff @(posedge clock) begin
      sum_w_ff     <= sum_w_in;
      cnt_w_ff     <= cnt_w_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      q_ff         <= q_in;
      step_ff      <= step_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_spike_sum   = rsp_sum_ff;
   assign rsp_rate_byte   = rsp_rate_ff;
   assign rsp_empty_group = rsp_empty_ff;

   // checks on the accumulator, divider and sequencer
`include "masked_segment_spike_rate_assert.svh"

   `MSR_ASSERT_NOW(a_sum_bounded, clock, reset, 1'b1, (25'(sum_acc_ff) <= 25'(cnt_acc_ff) * 25'd255), "sum exceeds 255 per counted element")
   `MSR_ASSERT_NOW(a_div_invariant, clock, reset, state_ff == ST_DIV, ((msr_pkg::RemWidth+1)'(rem_ff) < {dsh_ff, 1'b0}), "divider remainder out of range")
   `MSR_ASSERT_NEXT(a_last_stalls, clock, reset, req_beat && req_group_last, !req_ready && cnt_acc_ff == '0 && sum_acc_ff == '0, "group end did not start the divide")
   `MSR_ASSERT_NOW(a_empty_result, clock, reset, rsp_valid_ff && rsp_empty_ff, rsp_rate_ff == msr_pkg::RateZero && rsp_sum_ff == '0, "empty group with nonzero result")

endmodule

`default_nettype wire

FILE: sim/tb_masked_segment_spike_rate.sv
// self-checking testbench for masked_segment_spike_rate: beats in, one sum and rate per group
// depends on msr_pkg and the masked_segment_spike_rate rtl; nothing else
`default_nettype none

module tb_masked_segment_spike_rate;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DirectedRows = 22;
   localparam int RandomBeats  = 1050 - DirectedRows;
   localparam int HoldAfter    = 30;
   localparam int HoldCycles   = 400;
   localparam int DrainCycles  = 30;
   localparam int CycleLimit   = 200_000;

   typedef struct packed {
      logic [msr_pkg::SumWidth-1:0]  spike_sum;
      logic [msr_pkg::RateWidth-1:0] rate_byte;
      logic                          empty_group;
   } group_result_type;

   typedef struct packed {
      logic [msr_pkg::ValueWidth-1:0] spike_value;
      logic                           excluded;
      logic                           group_last;
      logic                           typed;
      group_result_type               result;
   } directed_row_type;

   typedef enum int {
      StyleDense,
      StyleSparse,
      StyleExcluded,
      StyleMixed
   } group_style_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [msr_pkg::ValueWidth-1:0] req_spike_value = '0;
   logic                           req_excluded = 1'b0;
   logic                           req_group_last = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [msr_pkg::SumWidth-1:0]   rsp_spike_sum;
   logic [msr_pkg::RateWidth-1:0]  rsp_rate_byte;
   logic                           rsp_empty_group;

   // predictor state: masked running sum and included count
   logic [msr_pkg::SumWidth-1:0]   acc_sum = '0;
   logic [msr_pkg::CountWidth-1:0] acc_included = '0;

   group_result_type pending_groups[$];

   int mismatch_count  = 0;
   int beats_sent      = 0;
   int groups_checked  = 0;
   int empty_seen      = 0;
   int fractional_seen = 0;
   int cycle_count     = 0;
   int req_calm_left   = 0;
   int rsp_calm_left   = 0;
   bit long_hold_done  = 1'b0;

   // directed rows; typed rows carry their result, others go through the predictor
   directed_row_type directed_rows [DirectedRows] = '{
      // single zero right after reset
      '{8'd0,   1'b0, 1'b1, 1'b1, '{24'd0,   8'd0,   1'b0}},
      // single full-scale byte
      '{8'd255, 1'b0, 1'b1, 1'b1, '{24'd255, 8'd255, 1'b0}},
      // single excluded beats: empty groups
      '{8'd255, 1'b1, 1'b1, 1'b1, '{24'd0,   8'd0,   1'b1}},
      '{8'd0,   1'b1, 1'b1, 1'b1, '{24'd0,   8'd0,   1'b1}},
      // 1 of 2: rate lands exactly on a half, rounds up
      '{8'd1,   1'b0, 1'b0, 1'b0, '0},
      '{8'd0,   1'b0, 1'b1, 1'b0, '0},
      // 1 of 3
      '{8'd0,   1'b0, 1'b0, 1'b0, '0},
      '{8'd0,   1'b0, 1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b1, 1'b0, '0},
      // excluded beats mixed in, last beat excluded
      '{8'd200, 1'b1, 1'b0, 1'b0, '0},
      '{8'd0,   1'b0, 1'b0, 1'b0, '0},
      '{8'd1,   1'b1, 1'b0, 1'b0, '0},
      '{8'd1,   1'b0, 1'b0, 1'b0, '0},
      '{8'd77,  1'b1, 1'b1, 1'b0, '0},
      // multi-beat group with everything excluded
      '{8'd0,   1'b1, 1'b0, 1'b0, '0},
      '{8'd170, 1'b1, 1'b0, 1'b0, '0},
      '{8'd255, 1'b1, 1'b1, 1'b1, '{24'd0,   8'd0,   1'b1}},
      // rate saturates once the mean reaches one
      '{8'd128, 1'b0, 1'b0, 1'b0, '0},
      '{8'd127, 1'b0, 1'b1, 1'b0, '0},
      '{8'd85,  1'b0, 1'b0, 1'b0, '0},
      '{8'd170, 1'b0, 1'b1, 1'b0, '0},
      '{8'd0,   1'b0, 1'b1, 1'b0, '0}
   };

   masked_segment_spike_rate u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_spike_value (req_spike_value),
      .req_excluded    (req_excluded),
      .req_group_last  (req_group_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_spike_sum   (rsp_spike_sum),
      .rsp_rate_byte   (rsp_rate_byte),
      .rsp_empty_group (rsp_empty_group)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d groups still pending",
                  cycle_count, pending_groups.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // folds one beat into the running group; returns 1 with the group result at group end
   function automatic bit fold_beat(input logic [msr_pkg::ValueWidth-1:0] value,
                                    input logic excluded, input logic group_last,
                                    output group_result_type result);
      logic [msr_pkg::SumWidth:0] widened;
      logic [63:0]                dividend;
      logic [63:0]                divisor;
      logic [63:0]                quotient;
      result = '0;
      if (!excluded) begin
         widened = {1'b0, acc_sum} + (msr_pkg::SumWidth+1)'(value);
         acc_sum = (widened > (msr_pkg::SumWidth+1)'(msr_pkg::SumMax)) ? msr_pkg::SumMax
                 : widened[msr_pkg::SumWidth-1:0];
         if (acc_included < msr_pkg::CountMax)
            acc_included = acc_included + 1'b1;
      end
      if (!group_last)
         return 1'b0;
      result.spike_sum   = acc_sum;
      result.empty_group = (acc_included == '0);
      result.rate_byte   = msr_pkg::RateZero;
      // round half up: (2*255*sum + count) / (2*count), capped at full scale
      if (acc_included != '0) begin
         dividend = 64'd510 * 64'(acc_sum) + 64'(acc_included);
         divisor  = 64'd2 * 64'(acc_included);
         quotient = dividend / divisor;
         result.rate_byte = (quotient > 64'(msr_pkg::RateMax)) ? msr_pkg::RateMax
                          : quotient[msr_pkg::RateWidth-1:0];
      end
      acc_sum      = '0;
      acc_included = '0;
      return 1'b1;
   endfunction

   // idle gap for one beat: mostly drawn at random, with calm stretches of no idling
   task automatic draw_gap(inout int calm_left, output int gap);
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(20, 60);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 9);
      end
   endtask

   task automatic report_mismatch(input string field, input longint expected,
                                  input longint actual);
      mismatch_count++;
      $display("MISMATCH at cycle %0d on %s: expected %0d, got %0d",
               cycle_count, field, expected, actual);
   endtask

   // offers one beat and returns at the edge that accepts it
   task automatic send_beat(input logic [msr_pkg::ValueWidth-1:0] value, input logic excluded,
                            input logic group_last, input int gap, input bit typed,
                            input group_result_type typed_result);
      group_result_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_spike_value <= value;
      req_excluded    <= excluded;
      req_group_last  <= group_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if (fold_beat(value, excluded, group_last, predicted))
         pending_groups.push_back(typed ? typed_result : predicted);
   endtask

   // result side: random stalls, one long hold-off, check against the oldest group
   initial begin
      int               idle;
      group_result_type expected;
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && groups_checked == HoldAfter) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         draw_gap(rsp_calm_left, idle);
         if (idle > 0) begin
            rsp_ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_groups.size() == 0) begin
            report_mismatch("result with no group pending", longint'(0),
                            longint'(rsp_spike_sum));
         end else begin
            expected = pending_groups.pop_front();
            groups_checked++;
            if (expected.empty_group)
               empty_seen++;
            if (expected.rate_byte != msr_pkg::RateZero
                && expected.rate_byte != msr_pkg::RateMax)
               fractional_seen++;
            if (rsp_spike_sum !== expected.spike_sum)
               report_mismatch("spike_sum", longint'(expected.spike_sum),
                               longint'(rsp_spike_sum));
            if (rsp_rate_byte !== expected.rate_byte)
               report_mismatch("rate_byte", longint'(expected.rate_byte),
                               longint'(rsp_rate_byte));
            if (rsp_empty_group !== expected.empty_group)
               report_mismatch("empty_group", longint'(expected.empty_group),
                               longint'(rsp_empty_group));
         end
      end
   end

   // request side: directed rows, then random groups
   initial begin
      int                             gap;
      int                             random_beats;
      int                             group_len;
      int                             i;
      group_style_type                style;
      logic [msr_pkg::ValueWidth-1:0] value;
      logic                           excluded;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (i = 0; i < DirectedRows; i++) begin
         draw_gap(req_calm_left, gap);
         send_beat(directed_rows[i].spike_value, directed_rows[i].excluded,
                   directed_rows[i].group_last, gap, directed_rows[i].typed,
                   directed_rows[i].result);
      end

      // random groups: mostly short, now and then a few hundred beats
      random_beats = 0;
      while (random_beats < RandomBeats) begin
         group_len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 600)
                                                  : $urandom_range(1, 12);
         // last group ends exactly on the beat budget
         if (group_len > RandomBeats - random_beats)
            group_len = RandomBeats - random_beats;
         style = group_style_type'($urandom_range(0, 3));
         for (i = 0; i < group_len; i++) begin
            case (style)
               StyleDense: begin
                  value    = 8'($urandom_range(0, 255));
                  excluded = ($urandom_range(0, 3) == 0);
               end
               // mostly zero bytes so the mean stays below one and the rate is partial
               StyleSparse: begin
                  value    = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
                  excluded = ($urandom_range(0, 7) == 0);
               end
               StyleExcluded: begin
                  value    = 8'($urandom_range(0, 255));
                  excluded = 1'b1;
               end
               default: begin
                  value    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
                  excluded = 1'($urandom_range(0, 1));
               end
            endcase
            draw_gap(req_calm_left, gap);
            send_beat(value, excluded, i == group_len - 1, gap, 1'b0, '0);
            random_beats++;
         end
      end

      req_valid <= 1'b0;

      // drain, then give the block time to show any stray result
      while (pending_groups.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d beats sent in %0d cycles, %0d groups checked", beats_sent, cycle_count,
               groups_checked);
      $display("%0d empty groups, %0d groups with a partial rate, long hold-off done: %0d",
               empty_seen, fractional_seen, long_hold_done);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
